### hdl/kmd_pkg.sv
// Shared constants, operation codes and controller/datapath handshake types.
package kmd_pkg;

  // Source indexing and configuration widths.
  localparam int NSRC  = 8;
  localparam int SRC_W = 3;
  localparam int CFG_W = 4;

  // Record geometry: three 64-bit key words and one payload word.
  localparam int KEY_W    = 64;
  localparam int KEY_BITS = 3 * KEY_W;
  localparam int PAY_W    = 64;
  localparam int HEAD_W   = KEY_BITS + PAY_W;
  localparam int COUNT_W  = 40;
  localparam int OP_W     = 2;

  // Operation codes of an input request.
  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_END    = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  // Reset value of the source count register and the "nothing awaited" mark.
  localparam logic [CFG_W-1:0] SIU_RESET  = CFG_W'(NSRC);
  localparam logic [CFG_W-1:0] AWAIT_NONE = CFG_W'(NSRC);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic scan;
    logic finish;
  } kmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic item_ok;
    logic scan_end;
    logic out_free;
  } kmd_status_t;

endpackage

### hdl/kmd_in_if.sv
// Input request channel: operation, source index and one record.
interface kmd_in_if import kmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SRC_W-1:0]  source;
  logic [KEY_W-1:0]  key_word0;
  logic [KEY_W-1:0]  key_word1;
  logic [KEY_W-1:0]  key_word2;
  logic [PAY_W-1:0]  payload;

  modport src (
    output valid, op, source, key_word0, key_word1, key_word2, payload,
    input  ready
  );

  modport snk (
    input  valid, op, source, key_word0, key_word1, key_word2, payload,
    output ready
  );
endinterface

### hdl/kmd_out_if.sv
// Result channel: emitted record, refill request and merge status.
interface kmd_out_if import kmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               record_valid;
  logic [KEY_W-1:0]   out_key0;
  logic [KEY_W-1:0]   out_key1;
  logic [KEY_W-1:0]   out_key2;
  logic [PAY_W-1:0]   out_payload;
  logic               refill_valid;
  logic [SRC_W-1:0]   refill_source;
  logic               merge_done;
  logic [COUNT_W-1:0] emitted_count;
  logic               order_error;

  modport src (
    output valid, record_valid, out_key0, out_key1, out_key2, out_payload,
           refill_valid, refill_source, merge_done, emitted_count, order_error,
    input  ready
  );

  modport snk (
    input  valid, record_valid, out_key0, out_key1, out_key2, out_payload,
           refill_valid, refill_source, merge_done, emitted_count, order_error,
    output ready
  );
endinterface

### hdl/kway_merge_dedup_unit.sv
// An accepted record or end mark goes through intake, a head scan over the n sources in use
// through the single 192-bit comparator, and commit; a start or an ignored request goes from
// intake straight to commit. A result waiting in the output register does not stop the next
// request from being taken and scanned.
// Reset (rst, synchronous, active high) clears the merge as a start request does.
module kway_merge_dedup_unit import kmd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [CFG_W-1:0] cfg_write_data,
  kmd_in_if.snk            in_ch,
  kmd_out_if.src           out_ch
);

  kmd_cmd_t    cmd;
  kmd_status_t status;

  // Sequencer.
  kmd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Head store, comparator and result register.
  kmd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

### hdl/kmd_ctrl.sv
// Controller state machine: take a request, scan the heads for an accepted record or end mark, then post the result.
module kmd_ctrl import kmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  kmd_status_t status,
  output kmd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } kmd_state_t;

  kmd_state_t state;
  kmd_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    cmd.in_ready = 1'b0;
    cmd.scan     = 1'b0;
    cmd.finish   = 1'b0;
    case (state)
      ST_IDLE: begin
        // Requests are held off while reset is asserted.
        cmd.in_ready = !rst;
        if (status.in_valid && !rst) begin
          // Accepted records and end marks need a head scan; others go straight out.
          state_next = status.item_ok ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_end) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Commit only when the output register can take the result.
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/kmd_datapath.sv
// Datapath: head store, sequential minimum scan, duplicate filter and output register.
module kmd_datapath import kmd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [CFG_W-1:0] cfg_write_data,
  kmd_in_if.snk            in_ch,
  kmd_out_if.src           out_ch,
  input  kmd_cmd_t         cmd,
  output kmd_status_t      status
);

  // Configuration and merge state.
  logic [CFG_W-1:0]    siu;
  logic [NSRC-1:0]     hv;
  logic [NSRC-1:0]     ended;
  logic                have_last;
  logic [KEY_BITS-1:0] last_key;
  logic [CFG_W-1:0]    awaited;
  logic [COUNT_W-1:0]  count;

  // Registered request class.
  logic op_ok;
  logic op_start;

  // Head store and scan pipeline.
  logic [HEAD_W-1:0]   mem [NSRC];
  logic [HEAD_W-1:0]   rd_q;
  logic [CFG_W-1:0]    scan_idx;
  logic                cmp_v;
  logic [SRC_W-1:0]    cmp_idx;
  logic                best_v;
  logic [KEY_BITS-1:0] best_key;
  logic [PAY_W-1:0]    best_pay;
  logic [SRC_W-1:0]    best_idx;

  // Output register.
  logic               out_valid;
  logic               o_record_valid;
  logic [KEY_BITS-1:0] o_key;
  logic [PAY_W-1:0]   o_payload;
  logic               o_refill_valid;
  logic [SRC_W-1:0]   o_refill_source;
  logic               o_merge_done;
  logic [COUNT_W-1:0] o_count;
  logic               o_order_error;

  // Combinational helpers.
  logic [CFG_W-1:0]    n_act;
  logic [NSRC-1:0]     in_use;
  logic [SRC_W-1:0]    src;
  logic [KEY_BITS-1:0] in_key;
  logic                door_ok;
  logic                take;
  logic [KEY_BITS-1:0] rd_key;
  logic [PAY_W-1:0]    rd_pay;
  logic                better;
  logic                settled;
  logic                all_ended;
  logic                emit_sel;
  logic                dup;
  logic                uniq;
  logic [COUNT_W-1:0]  count_inc;
  logic [COUNT_W-1:0]  count_next;

  // Number of sources in use, clamped to one through NSRC, and its mask.
  always_comb begin
    if (siu == '0) begin
      n_act = CFG_W'(1);
    end else if (siu > CFG_W'(NSRC)) begin
      n_act = CFG_W'(NSRC);
    end else begin
      n_act = siu;
    end
    for (int s = 0; s < NSRC; s++) begin
      in_use[s] = (CFG_W'(s) < n_act);
    end
  end

  // Turn check for the request at the input.
  assign src    = in_ch.source;
  assign in_key = {in_ch.key_word0, in_ch.key_word1, in_ch.key_word2};

  always_comb begin
    door_ok = 1'b0;
    if (in_ch.op == OP_RECORD || in_ch.op == OP_END) begin
      if (awaited == AWAIT_NONE) begin
        door_ok = in_use[src] && !hv[src] && !ended[src];
      end else begin
        door_ok = (src == awaited[SRC_W-1:0]);
      end
    end
  end

  assign take = in_ch.valid && cmd.in_ready;

  // Scan compare: a strictly smaller key wins, so ties keep the lower source.
  assign rd_key = rd_q[HEAD_W-1 -: KEY_BITS];
  assign rd_pay = rd_q[PAY_W-1:0];
  assign better = cmp_v && (!best_v || (rd_key < best_key));

  // Selection and duplicate decision.
  assign settled   = &(hv | ended | ~in_use);
  assign all_ended = &(ended | ~in_use);
  assign emit_sel  = op_ok && settled && best_v;
  assign dup       = have_last && (best_key == last_key);
  assign uniq      = emit_sel && !dup;
  assign count_inc = (count == {COUNT_W{1'b1}}) ? count : count + COUNT_W'(1);
  assign count_next = uniq ? count_inc : count;

  // Head store: one write port at request time, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (take && door_ok && in_ch.op == OP_RECORD) begin
      mem[src] <= {in_key, in_ch.payload};
    end
    rd_q <= mem[scan_idx[SRC_W-1:0]];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      siu       <= SIU_RESET;
      hv        <= '0;
      ended     <= '0;
      have_last <= 1'b0;
      awaited   <= AWAIT_NONE;
      count     <= '0;
      op_ok     <= 1'b0;
      op_start  <= 1'b0;
      scan_idx  <= '0;
      cmp_v     <= 1'b0;
      best_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        siu <= cfg_write_data;
      end

      // Output handshake.
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      // Request intake: clear on start, otherwise, if the turn check passes, store the head or end mark.
      if (take) begin
        op_ok    <= door_ok;
        op_start <= (in_ch.op == OP_START);
        scan_idx <= '0;
        cmp_v    <= 1'b0;
        best_v   <= 1'b0;
        if (in_ch.op == OP_START) begin
          hv        <= '0;
          ended     <= '0;
          have_last <= 1'b0;
          awaited   <= AWAIT_NONE;
          count     <= '0;
        end else if (door_ok) begin
          awaited <= AWAIT_NONE;
          if (in_ch.op == OP_RECORD) begin
            hv[src] <= 1'b1;
          end else begin
            ended[src] <= 1'b1;
          end
        end
      end

      // Scan step: issue one head read and compare the previous one.
      if (cmd.scan) begin
        scan_idx <= scan_idx + CFG_W'(1);
        cmp_v    <= (scan_idx < n_act) && hv[scan_idx[SRC_W-1:0]];
        if (better) begin
          best_v <= 1'b1;
        end
      end

      // Commit the selected head and request its refill.
      if (cmd.finish && emit_sel) begin
        hv[best_idx] <= 1'b0;
        awaited      <= {1'b0, best_idx};
        count        <= count_next;
        if (!dup) begin
          have_last <= 1'b1;
        end
      end
    end
  end

  // Data registers of the scan, the last key and the output.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= scan_idx[SRC_W-1:0];
      if (better) begin
        best_key <= rd_key;
        best_pay <= rd_pay;
        best_idx <= cmp_idx;
      end
    end
    if (cmd.finish) begin
      if (uniq) begin
        last_key <= best_key;
      end
      o_record_valid  <= uniq;
      o_key           <= uniq ? best_key : '0;
      o_payload       <= uniq ? best_pay : '0;
      o_refill_valid  <= emit_sel;
      o_refill_source <= emit_sel ? best_idx : '0;
      o_merge_done    <= !op_start && all_ended;
      o_count         <= op_start ? '0 : count_next;
      o_order_error   <= !op_ok && !op_start;
    end
  end

  // Ports and status.
  assign in_ch.ready          = cmd.in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.record_valid  = o_record_valid;
  assign out_ch.out_key0      = o_key[KEY_BITS-1 -: KEY_W];
  assign out_ch.out_key1      = o_key[KEY_BITS-KEY_W-1 -: KEY_W];
  assign out_ch.out_key2      = o_key[KEY_W-1:0];
  assign out_ch.out_payload   = o_payload;
  assign out_ch.refill_valid  = o_refill_valid;
  assign out_ch.refill_source = o_refill_source;
  assign out_ch.merge_done    = o_merge_done;
  assign out_ch.emitted_count = o_count;
  assign out_ch.order_error   = o_order_error;

  assign status.in_valid = in_ch.valid;
  assign status.item_ok  = door_ok;
  assign status.scan_end = (scan_idx == n_act);
  assign status.out_free = !out_valid || out_ch.ready;

endmodule
